FILE: src/bol_pkg.sv
// Shared types and codes for the bounded ordered list.
// Depends on nothing; imported by every module of the block.
package bol_pkg;

   localparam logic [2:0] MODE_INS_FRONT = 3'd0;
   localparam logic [2:0] MODE_INS_BACK  = 3'd1;
   localparam logic [2:0] MODE_INS_POS   = 3'd2;
   localparam logic [2:0] MODE_DEL_FRONT = 3'd3;
   localparam logic [2:0] MODE_DEL_BACK  = 3'd4;
   localparam logic [2:0] MODE_SHOW      = 3'd5;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_EMPTY = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;

   typedef struct packed {
      logic [2:0]         mode;
      logic signed [31:0] value;
      logic [7:0]         position;
   } req_type;

   typedef struct packed {
      logic signed [31:0] element;
      logic [1:0]         status;
      logic [4:0]         length;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic exec;
      logic show;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic single;
      logic show_last;
   } stat_type;

endpackage

FILE: src/bol_ctrl.sv
// Handshake controller for the bounded ordered list.
// Uses bol_pkg; drives bol_dp through cmd_type and reads stat_type.
module bol_ctrl
   import bol_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_mode,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output cmd_type    cmd,
   input  stat_type   stat
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SHOW = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      accept;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = out_free ? 1'b0 : rsp_valid_ff;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.exec     = 1'b1;
               rsp_valid_in = 1'b1;
               if (req_mode == MODE_SHOW && !stat.empty && !stat.single) begin
                  state_in = ST_SHOW;
               end
            end
         end
         ST_SHOW: begin
            if (out_free) begin
               cmd.show     = 1'b1;
               rsp_valid_in = 1'b1;
               if (stat.show_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: src/bol_dp.sv
// Datapath of the bounded ordered list: shifting cells, length and result register.
// Uses bol_pkg; commanded by bol_ctrl.
module bol_dp
   import bol_pkg::*;
#(
   parameter int DEPTH = 16
)
(
   input  logic     clock,
   input  logic     reset,
   input  req_type  req,
   input  cmd_type  cmd,
   output stat_type stat,
   output rsp_type  rsp
);

   localparam int LEN_W = $clog2(DEPTH + 1);

   logic signed [31:0] cells_ff [DEPTH];
   logic signed [31:0] cells_in [DEPTH];
   logic signed [31:0] shr      [DEPTH];
   logic signed [31:0] shl      [DEPTH];
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [LEN_W-1:0]   show_idx_ff, show_idx_in;
   logic [LEN_W-1:0]   len_dec;
   logic [LEN_W-1:0]   idx;
   logic [8:0]         pos_w;
   logic [8:0]         len_w;
   logic [31:0]        len_ext;
   logic               full;
   rsp_type            rsp_ff, rsp_in;

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_first
         assign shr[g] = req.value;
      end else begin : g_rest
         assign shr[g] = cells_ff[g-1];
      end
      if (g == DEPTH - 1) begin : g_tail
         assign shl[g] = cells_ff[g];
      end else begin : g_body
         assign shl[g] = cells_ff[g+1];
      end
   end

   assign len_dec = len_ff - LEN_W'(1);
   assign full    = len_ff >= LEN_W'(DEPTH);
   assign pos_w   = {1'b0, req.position};
   assign len_w   = 9'(len_ff);

   assign stat.empty     = len_ff == '0;
   assign stat.single    = len_ff == LEN_W'(1);
   assign stat.show_last = show_idx_ff == len_dec;

   always_comb begin
      case (req.mode)
         MODE_INS_FRONT: idx = '0;
         MODE_INS_BACK:  idx = len_ff;
         default: begin
            if (pos_w <= 9'd1) begin
               idx = '0;
            end else if (pos_w > len_w + 9'd1) begin
               idx = len_ff;
            end else begin
               idx = LEN_W'(pos_w - 9'd1);
            end
         end
      endcase
   end

   always_comb begin
      cells_in       = cells_ff;
      len_in         = len_ff;
      show_idx_in    = show_idx_ff;
      rsp_in         = rsp_ff;
      if (cmd.exec) begin
         rsp_in.element = '0;
         rsp_in.status  = STAT_OK;
         rsp_in.last    = 1'b1;
         case (req.mode)
            MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_POS: begin
               if (full) begin
                  rsp_in.status = STAT_FULL;
               end else begin
                  for (int i = 0; i < DEPTH; i++) begin
                     if (LEN_W'(i) == idx) begin
                        cells_in[i] = req.value;
                     end else if (LEN_W'(i) > idx) begin
                        cells_in[i] = shr[i];
                     end
                  end
                  len_in = len_ff + LEN_W'(1);
               end
            end
            MODE_DEL_FRONT, MODE_DEL_BACK: begin
               if (stat.empty) begin
                  rsp_in.status = STAT_EMPTY;
               end else begin
                  if (req.mode == MODE_DEL_FRONT) begin
                     cells_in = shl;
                  end
                  len_in = len_dec;
               end
            end
            MODE_SHOW: begin
               if (stat.empty) begin
                  rsp_in.status = STAT_EMPTY;
               end else begin
                  rsp_in.element = cells_ff[0];
                  rsp_in.last    = stat.single;
                  for (int i = 0; i < DEPTH; i++) begin
                     if (LEN_W'(i) == len_dec) begin
                        cells_in[i] = cells_ff[0];
                     end else if (LEN_W'(i) < len_dec) begin
                        cells_in[i] = shl[i];
                     end
                  end
                  show_idx_in = LEN_W'(1);
               end
            end
            default: begin
               rsp_in.status = STAT_OK;
            end
         endcase
      end else if (cmd.show) begin
         rsp_in.element = cells_ff[0];
         rsp_in.status  = STAT_OK;
         rsp_in.last    = stat.show_last;
         for (int i = 0; i < DEPTH; i++) begin
            if (LEN_W'(i) == len_dec) begin
               cells_in[i] = cells_ff[0];
            end else if (LEN_W'(i) < len_dec) begin
               cells_in[i] = shl[i];
            end
         end
         show_idx_in = show_idx_ff + LEN_W'(1);
      end
      len_ext = 32'(len_in);
      if (cmd.exec || cmd.show) begin
         rsp_in.length = len_ext[4:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff      <= '0;
         show_idx_ff <= '0;
      end else begin
         len_ff      <= len_in;
         show_idx_ff <= show_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cells_ff <= cells_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp = rsp_ff;

endmodule

FILE: src/bounded_ordered_list_unit.sv
// Bounded ordered list: up to DEPTH signed 32-bit values in shifting cells.
// Request channel req_valid/req_stall/req_data carries mode, value and position.
// Response channel rsp_valid/rsp_stall/rsp_data returns element, status, length, last.
// Inserts and deletes are registered: the response shows in the cycle after the
// request is taken, and a new request is taken every cycle while the response
// side keeps up.
// Display of N elements emits N responses, one per cycle while the response side
// keeps up, rotating the cells so the front is always read; the request side is
// stalled until the last of them has been issued. An empty display or delete gives
// one response with status empty; an insert into a full list gives one response
// with status full and changes nothing. Reset empties the list and drops any pending response.
// When rsp_stall is high with a response pending, the response register holds
// and req_stall rises until that response is taken; nothing is lost or repeated.
// Uses bol_pkg, bol_ctrl and bol_dp.
module bounded_ordered_list_unit
   import bol_pkg::*;
#(
   parameter int DEPTH = 16
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type  cmd;
   stat_type stat;

   bol_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_mode  (req_data.mode),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   bol_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock (clock),
      .reset (reset),
      .req   (req_data),
      .cmd   (cmd),
      .stat  (stat),
      .rsp   (rsp_data)
   );

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for bounded_ordered_list_unit: directed table, then random requests.
// Predicts responses from its list copy (typed rows: the table) and compares every field.
// Depends on bol_pkg and the RTL of bounded_ordered_list_unit.
module tb_top;
   import bol_pkg::*;

   localparam int LIST_DEPTH = 16;
   localparam logic [2:0] MODE_SPARE_LO = 3'd6;
   localparam logic [2:0] MODE_SPARE_HI = 3'd7;
   localparam int RANDOM_PER_PHASE = 111;
   localparam int HOLD_CYCLES = 80;

   typedef struct {
      req_type    stim;
      int         reps;
      bit         typed;
      rsp_type    fixed;
   } step_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   logic [31:0]  cells [LIST_DEPTH];
   int unsigned  held = 0;
   rsp_type      expected_rsp [$];
   step_row_type plan [$];
   bit           failed = 1'b0;
   int           send_idle_pct = 0;
   int           recv_idle_pct = 0;
   logic         hold_armed = 1'b0;
   bit           hold_done = 1'b0;
   int           hold_left = 0;

   bounded_ordered_list_unit #(.DEPTH(LIST_DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #10 clock = ~clock;

   task automatic model_request(input req_type r);
      rsp_type e;
      int unsigned idx;
      int unsigned i;
      e = '0;
      e.last = 1'b1;
      case (r.mode)
         MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_POS: begin
            if (held >= LIST_DEPTH) begin
               e.status = STAT_FULL;
            end else begin
               if (r.mode == MODE_INS_FRONT)
                  idx = 0;
               else if (r.mode == MODE_INS_BACK)
                  idx = held;
               else if (r.position <= 1)
                  idx = 0;
               else if (r.position > held + 1)
                  idx = held;
               else
                  idx = r.position - 1;
               for (i = held; i > idx; i--)
                  cells[i] = cells[i - 1];
               cells[idx] = r.value;
               held++;
               e.status = STAT_OK;
            end
            e.length = 5'(held);
            expected_rsp.push_back(e);
         end
         MODE_DEL_FRONT, MODE_DEL_BACK: begin
            if (held == 0) begin
               e.status = STAT_EMPTY;
            end else begin
               if (r.mode == MODE_DEL_FRONT)
                  for (i = 0; i + 1 < held; i++)
                     cells[i] = cells[i + 1];
               held--;
               e.status = STAT_OK;
            end
            e.length = 5'(held);
            expected_rsp.push_back(e);
         end
         MODE_SHOW: begin
            if (held == 0) begin
               e.status = STAT_EMPTY;
               expected_rsp.push_back(e);
            end else begin
               for (i = 0; i < held; i++) begin
                  e.element = cells[i];
                  e.status = STAT_OK;
                  e.length = 5'(held);
                  e.last = (i + 1 == held);
                  expected_rsp.push_back(e);
               end
            end
         end
         default: begin
            e.status = STAT_OK;
            e.length = 5'(held);
            expected_rsp.push_back(e);
         end
      endcase
   endtask

   task automatic offer(input req_type r, input bit typed, input rsp_type fixed);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      model_request(r);
      if (typed) begin
         void'(expected_rsp.pop_back());
         expected_rsp.push_back(fixed);
      end
   endtask

   task automatic add_step(input logic [2:0] mode, input logic [31:0] value,
                           input logic [7:0] position, input int reps,
                           input bit typed, input logic [1:0] status,
                           input logic [4:0] length);
      step_row_type row;
      row.stim.mode = mode;
      row.stim.value = value;
      row.stim.position = position;
      row.reps = reps;
      row.typed = typed;
      row.fixed = '0;
      row.fixed.status = status;
      row.fixed.length = length;
      row.fixed.last = 1'b1;
      plan.push_back(row);
   endtask

   function automatic req_type random_request(input int grow_pct);
      req_type r;
      int pick;
      pick = $urandom_range(99);
      r.value = $urandom;
      if ($urandom_range(7) == 0) begin
         case ($urandom_range(3))
            0: r.value = 32'h7FFF_FFFF;
            1: r.value = 32'h8000_0000;
            2: r.value = 32'h0000_0000;
            default: r.value = 32'hFFFF_FFFF;
         endcase
      end
      if ($urandom_range(1) == 0)
         r.position = 8'($urandom_range(held + 2));
      else
         r.position = 8'($urandom_range(255));
      if (pick < 3) begin
         r.mode = ($urandom_range(1) == 0) ? MODE_SPARE_LO : MODE_SPARE_HI;
      end else if (pick < 13) begin
         r.mode = MODE_SHOW;
      end else if ($urandom_range(99) < grow_pct) begin
         case ($urandom_range(3))
            0: r.mode = MODE_INS_FRONT;
            1: r.mode = MODE_INS_BACK;
            default: r.mode = MODE_INS_POS;
         endcase
      end else begin
         r.mode = ($urandom_range(1) == 0) ? MODE_DEL_FRONT : MODE_DEL_BACK;
      end
      return r;
   endfunction

   task automatic check_response(input rsp_type got);
      rsp_type want;
      if (expected_rsp.size() == 0) begin
         $display("%0t: unexpected response element=%0d status=%0d length=%0d last=%0b",
                  $time, got.element, got.status, got.length, got.last);
         failed = 1'b1;
         return;
      end
      want = expected_rsp.pop_front();
      if (got.element !== want.element || got.status !== want.status ||
          got.length !== want.length || got.last !== want.last) begin
         $display("%0t: mismatch expected element=%0d status=%0d length=%0d last=%0b",
                  $time, want.element, want.status, want.length, want.last);
         $display("%0t:          actual   element=%0d status=%0d length=%0d last=%0b",
                  $time, got.element, got.status, got.length, got.last);
         failed = 1'b1;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         check_response(rsp_data);
      if (hold_armed && !hold_done) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   initial begin
      int phase;
      int n;
      int k;
      step_row_type row;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 35;
      recv_idle_pct = 62;

      add_step(MODE_DEL_FRONT, 32'h0,         8'd0,   1,  1, STAT_EMPTY, 5'd0);
      add_step(MODE_DEL_BACK,  32'hFFFF_FFFF, 8'd255, 1,  1, STAT_EMPTY, 5'd0);
      add_step(MODE_SHOW,      32'h0,         8'd0,   1,  1, STAT_EMPTY, 5'd0);
      add_step(MODE_SPARE_LO,  32'h1234_5678, 8'd0,   1,  1, STAT_OK,    5'd0);
      add_step(MODE_INS_POS,   32'h7FFF_FFFF, 8'd0,   1,  1, STAT_OK,    5'd1);
      add_step(MODE_INS_FRONT, 32'h8000_0000, 8'd0,   1,  1, STAT_OK,    5'd2);
      add_step(MODE_INS_POS,   32'hFFFF_FFFF, 8'd1,   1,  1, STAT_OK,    5'd3);
      add_step(MODE_INS_BACK,  32'h0,         8'd0,   1,  1, STAT_OK,    5'd4);
      add_step(MODE_INS_POS,   32'h5,         8'd255, 1,  1, STAT_OK,    5'd5);
      add_step(MODE_INS_POS,   32'h5555_AAAA, 8'd3,   1,  1, STAT_OK,    5'd6);
      add_step(MODE_INS_POS,   32'hFFFF_FFFE, 8'd7,   1,  1, STAT_OK,    5'd7);
      add_step(MODE_INS_POS,   32'd77,        8'd9,   1,  1, STAT_OK,    5'd8);
      add_step(MODE_SHOW,      32'h0,         8'd0,   1,  0, STAT_OK,    5'd0);
      add_step(MODE_SPARE_HI,  32'hAAAA_5555, 8'd128, 1,  1, STAT_OK,    5'd8);
      add_step(MODE_DEL_FRONT, 32'h0,         8'd0,   1,  1, STAT_OK,    5'd7);
      add_step(MODE_DEL_BACK,  32'h0,         8'd0,   1,  1, STAT_OK,    5'd6);
      add_step(MODE_INS_BACK,  32'hA5A5_A5A5, 8'd0,   10, 0, STAT_OK,    5'd0);
      add_step(MODE_INS_FRONT, 32'h1,         8'd0,   1,  1, STAT_FULL,  5'd16);
      add_step(MODE_INS_POS,   32'h2,         8'd4,   1,  1, STAT_FULL,  5'd16);
      add_step(MODE_INS_BACK,  32'h3,         8'd0,   1,  1, STAT_FULL,  5'd16);
      add_step(MODE_SHOW,      32'h0,         8'd0,   1,  0, STAT_OK,    5'd0);
      add_step(MODE_DEL_BACK,  32'h0,         8'd0,   15, 0, STAT_OK,    5'd0);
      add_step(MODE_SHOW,      32'h0,         8'd0,   1,  0, STAT_OK,    5'd0);
      add_step(MODE_DEL_FRONT, 32'h0,         8'd0,   1,  1, STAT_OK,    5'd0);
      add_step(MODE_SHOW,      32'h0,         8'd0,   1,  1, STAT_EMPTY, 5'd0);

      foreach (plan[i]) begin
         row = plan[i];
         for (k = 0; k < row.reps; k++)
            offer(row.stim, row.typed, row.fixed);
      end

      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 35;
               recv_idle_pct = 62;
            end
            1: begin
               send_idle_pct = 62;
               recv_idle_pct = 35;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (n = 0; n < RANDOM_PER_PHASE; n++) begin
            if (phase == 0 && n == 40)
               hold_armed <= 1'b1;
            case ((n / 40) % 3)
               0: offer(random_request(80), 1'b0, '0);
               1: offer(random_request(45), 1'b0, '0);
               default: offer(random_request(20), 1'b0, '0);
            endcase
         end
      end
      req_valid <= 1'b0;

      while (expected_rsp.size() != 0)
         @(posedge clock);
      repeat (LIST_DEPTH + 8) @(posedge clock);
      if (!failed)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #4000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
